// File: hw/rtl/vmlru_pkg.sv
package vmlru_pkg;

    // Request codes carried in req_type.
    localparam logic REQ_INSERT = 1'b0;
    localparam logic REQ_PRUNE  = 1'b1;

    // Configuration register indexes.
    localparam logic CFG_INV_VOXEL_SIZE = 1'b0;
    localparam logic CFG_VOXEL_CAPACITY = 1'b1;

    localparam int FIELD_W = 24;
    localparam int SUM_W   = 56;

    // Input word.
    typedef struct packed {
        logic                      req_type;
        logic signed [FIELD_W-1:0] coord_x;
        logic signed [FIELD_W-1:0] coord_y;
        logic signed [FIELD_W-1:0] coord_z;
        logic [31:0]               timestamp;
        logic [31:0]               max_age;
    } t_in_item;

    // Result word.
    typedef struct packed {
        logic signed [FIELD_W-1:0] voxel_x;
        logic signed [FIELD_W-1:0] voxel_y;
        logic signed [FIELD_W-1:0] voxel_z;
        logic                      was_present;
        logic                      did_evict;
        logic signed [FIELD_W-1:0] evicted_x;
        logic signed [FIELD_W-1:0] evicted_y;
        logic signed [FIELD_W-1:0] evicted_z;
        logic [31:0]               point_count;
        logic [8:0]                removed_count;
    } t_out_item;

    // Per-voxel statistics held in the data memory.
    typedef struct packed {
        logic [31:0]      count;
        logic [SUM_W-1:0] sum_x;
        logic [SUM_W-1:0] sum_y;
        logic [SUM_W-1:0] sum_z;
        logic [31:0]      last_time;
    } t_slot_data;

    // Sequencer states.
    typedef enum logic [14:0] {
        ST_IDLE   = 15'b000000000000001,
        ST_KEY    = 15'b000000000000010,
        ST_SCAN   = 15'b000000000000100,
        ST_DECIDE = 15'b000000000001000,
        ST_H_DRD  = 15'b000000000010000,
        ST_H_UNL  = 15'b000000000100000,
        ST_PUSH1  = 15'b000000001000000,
        ST_PUSH2  = 15'b000000010000000,
        ST_POST   = 15'b000000100000000,
        ST_EV_RD  = 15'b000001000000000,
        ST_EV_WR  = 15'b000010000000000,
        ST_ALLOC  = 15'b000100000000000,
        ST_PR_RD  = 15'b001000000000000,
        ST_PR_CHK = 15'b010000000000000,
        ST_OUT    = 15'b100000000000000
    } t_state;

endpackage

// File: hw/rtl/vmlru_key.sv
module vmlru_key #(
    parameter int COORD_BITS = 24
) (
    input  logic                                   i_clk,
    input  logic [2:0][vmlru_pkg::FIELD_W-1:0]     i_coord,
    input  logic [23:0]                            i_inv,
    output logic [2:0][COORD_BITS-1:0]             o_key
);

    localparam int PROD_W = vmlru_pkg::FIELD_W + 25;

    logic signed [PROD_W-1:0] r_prod [3];
    logic signed [PROD_W-1:0] shifted [3];

    // One multiplier per axis, registered.
    always_ff @(posedge i_clk) begin
        for (int a = 0; a < 3; a++) begin
            r_prod[a] <= $signed(i_coord[a]) * $signed({1'b0, i_inv});
        end
    end

    // The arithmetic shift rounds toward minus infinity; keys wrap to COORD_BITS.
    always_comb begin
        for (int a = 0; a < 3; a++) begin
            shifted[a] = r_prod[a] >>> 24;
            o_key[a]   = shifted[a][COORD_BITS-1:0];
        end
    end

endmodule

// File: hw/rtl/voxel_map_lru_insert.sv
// Channel | Direction | Handshake                    | Word
// input   | in        | i_in_valid / o_in_ready      | i_in_data  (t_in_item)
// output  | out       | o_out_valid / i_out_ready    | o_out_data (t_out_item)
// config  | in        | i_cfg_we, i_cfg_index        | i_cfg_data (24 bits)
//
// An insert computes the key, then the lookup scans the key memory one entry a cycle.
// A present voxel has its statistics read, updated and moved to the head of the list,
// and the tail is evicted if the map is then over capacity; a new voxel evicts the tail
// first when the map is full and is then placed in a free slot. A prune reads and then
// checks each slot in turn on the data and link memories. Reset is synchronous and
// active low; it clears the valid bits at once, so no clearing pass runs. A result
// waits in the output register while the next word is accepted; the sequencer
// holds in its last state while that register is still full.
module voxel_map_lru_insert #(
    parameter int CAPACITY   = 256,
    parameter int COORD_BITS = 24
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  vmlru_pkg::t_in_item  i_in_data,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output vmlru_pkg::t_out_item o_out_data,
    input  logic                 i_cfg_we,
    input  logic                 i_cfg_index,
    input  logic [23:0]          i_cfg_data
);

    localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int UW = $clog2(CAPACITY + 1);
    localparam logic [IW-1:0] LAST = IW'(CAPACITY - 1);

    typedef logic [2:0][COORD_BITS-1:0] t_key;

    vmlru_pkg::t_state    r_state;
    vmlru_pkg::t_in_item  r_req;
    vmlru_pkg::t_out_item r_res;
    vmlru_pkg::t_out_item r_out;
    logic                 r_out_valid;

    logic [23:0]          r_inv;
    logic [8:0]           r_cap;
    logic [UW-1:0]        eff_cap;

    logic [CAPACITY-1:0]  r_valid;
    logic [IW-1:0]        r_head;
    logic [IW-1:0]        r_tail;
    logic [UW-1:0]        r_used;

    logic [IW-1:0]        r_scan;
    logic                 r_issue_done;
    logic                 r_cmp_go;
    logic [IW-1:0]        r_cmp_idx;
    logic                 r_hit_found;
    logic [IW-1:0]        r_hit;
    logic                 r_free_found;
    logic [IW-1:0]        r_slot;
    logic                 r_miss;
    logic [8:0]           r_removed;

    t_key                 key;
    logic [2:0][vmlru_pkg::FIELD_W-1:0] coords;

    // Memories.
    t_key                  key_mem  [CAPACITY];
    vmlru_pkg::t_slot_data data_mem [CAPACITY];
    logic [IW-1:0]         prev_mem [CAPACITY];
    logic [IW-1:0]         next_mem [CAPACITY];

    t_key                  key_q;
    vmlru_pkg::t_slot_data data_q;
    logic [IW-1:0]         prev_q;
    logic [IW-1:0]         next_q;

    logic                  key_we;
    logic [IW-1:0]         key_ra;
    logic                  data_we;
    vmlru_pkg::t_slot_data data_wd;
    logic [IW-1:0]         data_ra;
    logic [IW-1:0]         link_ra;
    logic                  next_we;
    logic [IW-1:0]         next_wa;
    logic [IW-1:0]         next_wd;
    logic                  prev_we;
    logic [IW-1:0]         prev_wa;
    logic [IW-1:0]         prev_wd;

    logic                  unlink_en;
    logic [IW-1:0]         unlink_u;
    logic                  prune_hit;
    logic                  key_match;
    vmlru_pkg::t_slot_data upd;

    assign o_in_ready  = (r_state == vmlru_pkg::ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    assign coords = {r_req.coord_x, r_req.coord_y, r_req.coord_z};

    vmlru_key #(.COORD_BITS(COORD_BITS)) u_key (
        .i_clk   (i_clk),
        .i_coord (coords),
        .i_inv   (r_inv),
        .o_key   (key)
    );

    function automatic logic [23:0] key_out(input logic [COORD_BITS-1:0] k);
        key_out = 24'($signed(k));
    endfunction

    // Capacity as the block uses it: zero acts as one, clipped at CAPACITY.
    always_comb begin
        if (r_cap == 9'd0) begin
            eff_cap = UW'(1);
        end else if (32'(r_cap) > 32'(CAPACITY)) begin
            eff_cap = UW'(CAPACITY);
        end else begin
            eff_cap = UW'(r_cap);
        end
    end

    // Memory read and write ports.
    always_ff @(posedge i_clk) begin
        if (key_we) begin
            key_mem[r_slot] <= key;
        end
        key_q <= key_mem[key_ra];
    end

    always_ff @(posedge i_clk) begin
        if (data_we) begin
            data_mem[r_slot] <= data_wd;
        end
        data_q <= data_mem[data_ra];
    end

    always_ff @(posedge i_clk) begin
        if (next_we) begin
            next_mem[next_wa] <= next_wd;
        end
        next_q <= next_mem[link_ra];
    end

    always_ff @(posedge i_clk) begin
        if (prev_we) begin
            prev_mem[prev_wa] <= prev_wd;
        end
        prev_q <= prev_mem[link_ra];
    end

    // Comparisons on the words coming out of the memories.
    assign key_match = (key_q == key);
    assign prune_hit = r_valid[r_scan] &&
        ({1'b0, data_q.last_time} + {1'b0, r_req.max_age} < {1'b0, r_req.timestamp});

    // Hit update: saturating count, wrapping sums, new time stamp.
    always_comb begin
        upd           = data_q;
        upd.count     = (data_q.count == 32'hFFFF_FFFF) ? data_q.count : data_q.count + 32'd1;
        upd.sum_x     = data_q.sum_x + vmlru_pkg::SUM_W'($signed(r_req.coord_x));
        upd.sum_y     = data_q.sum_y + vmlru_pkg::SUM_W'($signed(r_req.coord_y));
        upd.sum_z     = data_q.sum_z + vmlru_pkg::SUM_W'($signed(r_req.coord_z));
        upd.last_time = r_req.timestamp;
    end

    // Read addresses and write strobes by state.
    always_comb begin
        key_ra    = r_tail;
        data_ra   = r_slot;
        link_ra   = r_slot;
        key_we    = 1'b0;
        data_we   = 1'b0;
        data_wd   = upd;
        next_we   = 1'b0;
        next_wa   = prev_q;
        next_wd   = next_q;
        prev_we   = 1'b0;
        prev_wa   = next_q;
        prev_wd   = prev_q;
        unlink_en = 1'b0;
        unlink_u  = r_slot;
        case (r_state)
            vmlru_pkg::ST_SCAN: begin
                key_ra = r_scan;
            end
            vmlru_pkg::ST_EV_RD: begin
                key_ra  = r_tail;
                link_ra = r_tail;
            end
            vmlru_pkg::ST_PR_RD: begin
                data_ra = r_scan;
                link_ra = r_scan;
            end
            vmlru_pkg::ST_H_UNL: begin
                data_we   = 1'b1;
                unlink_en = 1'b1;
            end
            vmlru_pkg::ST_EV_WR: begin
                unlink_en = 1'b1;
                unlink_u  = r_tail;
            end
            vmlru_pkg::ST_PR_CHK: begin
                unlink_en = prune_hit;
                unlink_u  = r_scan;
            end
            vmlru_pkg::ST_ALLOC: begin
                key_we          = 1'b1;
                data_we         = 1'b1;
                data_wd.count   = 32'd1;
                data_wd.sum_x   = vmlru_pkg::SUM_W'($signed(r_req.coord_x));
                data_wd.sum_y   = vmlru_pkg::SUM_W'($signed(r_req.coord_y));
                data_wd.sum_z   = vmlru_pkg::SUM_W'($signed(r_req.coord_z));
                data_wd.last_time = r_req.timestamp;
            end
            vmlru_pkg::ST_PUSH1: begin
                next_we = 1'b1;
                next_wa = r_slot;
                next_wd = (r_used == '0) ? r_slot : r_head;
                prev_we = 1'b1;
                prev_wa = r_slot;
                prev_wd = r_slot;
            end
            vmlru_pkg::ST_PUSH2: begin
                prev_we = 1'b1;
                prev_wa = r_head;
                prev_wd = r_slot;
            end
            default: begin
            end
        endcase
        // Unlink: point the neighbors past the slot; no link is written on a side where the slot is an end of the list.
        if (unlink_en) begin
            next_we = (unlink_u != r_head);
            prev_we = (unlink_u != r_tail);
        end
    end

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inv <= 24'd131072;
            r_cap <= 9'd256;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                vmlru_pkg::CFG_INV_VOXEL_SIZE: r_inv <= i_cfg_data;
                vmlru_pkg::CFG_VOXEL_CAPACITY: r_cap <= i_cfg_data[8:0];
                default: begin
                end
            endcase
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == vmlru_pkg::ST_OUT && (!r_out_valid || i_out_ready)) begin
            r_out_valid <= 1'b1;
            r_out       <= r_res;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Sequencer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= vmlru_pkg::ST_IDLE;
            r_valid      <= '0;
            r_head       <= '0;
            r_tail       <= '0;
            r_used       <= '0;
            r_cmp_go     <= 1'b0;
            r_issue_done <= 1'b0;
        end else begin
            if (unlink_en) begin
                if (unlink_u == r_head) begin
                    r_head <= next_q;
                end
                if (unlink_u == r_tail) begin
                    r_tail <= prev_q;
                end
            end
            case (r_state)
                vmlru_pkg::ST_IDLE: begin
                    if (i_in_valid) begin
                        r_req        <= i_in_data;
                        r_res        <= '0;
                        r_scan       <= '0;
                        r_issue_done <= 1'b0;
                        r_cmp_go     <= 1'b0;
                        r_hit_found  <= 1'b0;
                        r_free_found <= 1'b0;
                        r_miss       <= 1'b0;
                        r_removed    <= '0;
                        r_state      <= (i_in_data.req_type == vmlru_pkg::REQ_PRUNE) ?
                                        vmlru_pkg::ST_PR_RD : vmlru_pkg::ST_KEY;
                    end
                end
                vmlru_pkg::ST_KEY: begin
                    r_state <= vmlru_pkg::ST_SCAN;
                end
                vmlru_pkg::ST_SCAN: begin
                    // Issue one key read a cycle; compare the word read the cycle before.
                    if (!r_issue_done) begin
                        r_cmp_go  <= 1'b1;
                        r_cmp_idx <= r_scan;
                        if (r_scan == LAST) begin
                            r_issue_done <= 1'b1;
                        end else begin
                            r_scan <= r_scan + IW'(1);
                        end
                    end else begin
                        r_cmp_go <= 1'b0;
                    end
                    if (r_cmp_go) begin
                        if (r_valid[r_cmp_idx] && key_match && !r_hit_found) begin
                            r_hit_found <= 1'b1;
                            r_hit       <= r_cmp_idx;
                        end
                        if (!r_valid[r_cmp_idx] && !r_free_found) begin
                            r_free_found <= 1'b1;
                            r_slot       <= r_cmp_idx;
                        end
                        if (r_cmp_idx == LAST) begin
                            r_state <= vmlru_pkg::ST_DECIDE;
                        end
                    end
                end
                vmlru_pkg::ST_DECIDE: begin
                    r_res.voxel_x <= key_out(key[2]);
                    r_res.voxel_y <= key_out(key[1]);
                    r_res.voxel_z <= key_out(key[0]);
                    if (r_hit_found) begin
                        r_slot            <= r_hit;
                        r_res.was_present <= 1'b1;
                        r_state           <= vmlru_pkg::ST_H_DRD;
                    end else begin
                        r_miss  <= 1'b1;
                        r_state <= (r_used >= eff_cap) ? vmlru_pkg::ST_EV_RD :
                                   vmlru_pkg::ST_ALLOC;
                    end
                end
                vmlru_pkg::ST_H_DRD: begin
                    r_state <= vmlru_pkg::ST_H_UNL;
                end
                vmlru_pkg::ST_H_UNL: begin
                    r_res.point_count <= upd.count;
                    r_used            <= r_used - UW'(1);
                    r_state           <= vmlru_pkg::ST_PUSH1;
                end
                vmlru_pkg::ST_ALLOC: begin
                    r_valid[r_slot]   <= 1'b1;
                    r_res.point_count <= 32'd1;
                    r_state           <= vmlru_pkg::ST_PUSH1;
                end
                vmlru_pkg::ST_PUSH1: begin
                    if (r_used == '0) begin
                        r_head  <= r_slot;
                        r_tail  <= r_slot;
                        r_used  <= r_used + UW'(1);
                        r_state <= vmlru_pkg::ST_POST;
                    end else begin
                        r_state <= vmlru_pkg::ST_PUSH2;
                    end
                end
                vmlru_pkg::ST_PUSH2: begin
                    r_head  <= r_slot;
                    r_used  <= r_used + UW'(1);
                    r_state <= vmlru_pkg::ST_POST;
                end
                vmlru_pkg::ST_POST: begin
                    r_state <= (!r_miss && r_used > eff_cap) ? vmlru_pkg::ST_EV_RD :
                               vmlru_pkg::ST_OUT;
                end
                vmlru_pkg::ST_EV_RD: begin
                    r_state <= vmlru_pkg::ST_EV_WR;
                end
                vmlru_pkg::ST_EV_WR: begin
                    r_res.did_evict <= 1'b1;
                    r_res.evicted_x <= key_out(key_q[2]);
                    r_res.evicted_y <= key_out(key_q[1]);
                    r_res.evicted_z <= key_out(key_q[0]);
                    r_valid[r_tail] <= 1'b0;
                    r_used          <= r_used - UW'(1);
                    if (r_miss) begin
                        // The new voxel takes the lowest free slot.
                        if (!r_free_found || r_tail < r_slot) begin
                            r_slot <= r_tail;
                        end
                        r_state <= vmlru_pkg::ST_ALLOC;
                    end else begin
                        r_state <= vmlru_pkg::ST_OUT;
                    end
                end
                vmlru_pkg::ST_PR_RD: begin
                    r_state <= vmlru_pkg::ST_PR_CHK;
                end
                vmlru_pkg::ST_PR_CHK: begin
                    if (prune_hit) begin
                        r_valid[r_scan] <= 1'b0;
                        r_used          <= r_used - UW'(1);
                        r_removed       <= r_removed + 9'd1;
                        r_res.removed_count <= r_removed + 9'd1;
                    end
                    if (r_scan == LAST) begin
                        r_state <= vmlru_pkg::ST_OUT;
                    end else begin
                        r_scan  <= r_scan + IW'(1);
                        r_state <= vmlru_pkg::ST_PR_RD;
                    end
                end
                vmlru_pkg::ST_OUT: begin
                    if (!r_out_valid || i_out_ready) begin
                        r_state <= vmlru_pkg::ST_IDLE;
                    end
                end
                default: begin
                    r_state <= vmlru_pkg::ST_IDLE;
                end
            endcase
        end
    end

    // The occupancy count never passes the slot store.
    a_used_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_used) <= 32'(CAPACITY))
        else $error("occupancy above slot count");

    // Between requests the occupancy count matches the valid bits.
    a_used_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == vmlru_pkg::ST_IDLE) |-> (32'($countones(r_valid)) == 32'(r_used)))
        else $error("occupancy count out of step with valid bits");

    // A lookup hit always points at a live slot.
    a_hit_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == vmlru_pkg::ST_DECIDE && r_hit_found) |-> r_valid[r_hit])
        else $error("hit on a free slot");

    // A new voxel is never placed over a live slot.
    a_alloc_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == vmlru_pkg::ST_ALLOC) |-> !r_valid[r_slot])
        else $error("allocation over a live slot");

endmodule
